[rtl/core/stvc_pkg.sv]
// ----------------------------------------------------------------------------
// stvc_pkg
// Shared types and constants for the scheduled thermostat valve controller:
// field widths, stream packing, table entry layout and valve mode codes.
// ----------------------------------------------------------------------------
package stvc_pkg;

    // Table shape: base entry plus scheduled windows
    localparam int NUM_WINDOWS  = 10;
    localparam int NUM_ENTRIES  = NUM_WINDOWS + 1;
    localparam int IDX_W        = $clog2(NUM_ENTRIES);

    // Field widths
    localparam int ENTRY_IDX_W  = 4;
    localparam int MIN_W        = 11;
    localparam int TEMP_W       = 12;
    localparam int HOUR_W       = 5;
    localparam int MINUTE_W     = 6;
    localparam int HOLD_W       = 16;
    localparam int MODE_W       = 2;

    // Time constants
    localparam logic [MIN_W-1:0]  DAY_MINUTES = MIN_W'(1440);
    localparam logic [HOLD_W-1:0] HOLD_MAX    = HOLD_W'(16'hFFFF);

    // Input tdata layout, lowest bit first
    localparam int IN_IDX_LO    = 0;
    localparam int IN_START_LO  = IN_IDX_LO + ENTRY_IDX_W;
    localparam int IN_STOP_LO   = IN_START_LO + MIN_W;
    localparam int IN_TON_LO    = IN_STOP_LO + MIN_W;
    localparam int IN_TOFF_LO   = IN_TON_LO + TEMP_W;
    localparam int IN_EN_BIT    = IN_TOFF_LO + TEMP_W;
    localparam int IN_HOUR_LO   = IN_EN_BIT + 1;
    localparam int IN_MINUTE_LO = IN_HOUR_LO + HOUR_W;
    localparam int IN_DISP_LO   = IN_MINUTE_LO + MINUTE_W;
    localparam int IN_BUSY_BIT  = IN_DISP_LO + TEMP_W;
    localparam int IN_USED_W    = IN_BUSY_BIT + 1;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_DATA_W   = MODE_W + 2 + ENTRY_IDX_W + HOLD_W;

    // Input item kinds carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Valve mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_CLOSED  = 2'd2
    } t_mode;

    // One schedule table entry
    typedef struct packed {
        logic [MIN_W-1:0]         start_min;
        logic [MIN_W-1:0]         stop_min;
        logic signed [TEMP_W-1:0] start_t;
        logic signed [TEMP_W-1:0] stop_t;
        logic                     enabled;
    } t_entry;

    // Reduce a minute value below two days into one day
    function automatic logic [MIN_W-1:0] day_wrap(input logic [MIN_W-1:0] m);
        logic [MIN_W-1:0] r;
        r = (m >= DAY_MINUTES) ? m - DAY_MINUTES : m;
        return r;
    endfunction

endpackage

[rtl/core/scheduled_thermostat_valve_control.sv]
// ----------------------------------------------------------------------------
// scheduled_thermostat_valve_control
// Schedule table with a window scan on each tick without motor_busy; one shared
// subtract/compare unit walks the windows and picks the entry that drives
// the open/close decision for the valve.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | tdata fields (low bit first)                | tuser
//  ----------+-----------+---------------------------------------------+---------
//  s_axis    | in        | entry_index, entry_start_minute,            | opcode
//            |           | entry_stop_minute, entry_start_temp,        |
//            |           | entry_stop_temp, entry_enabled, now_hour,   |
//            |           | now_minute, display_temp, motor_busy        |
//  m_axis    | out       | valve_state, drive_open, drive_close,       | skipped
//            |           | active_entry, hold_minutes                  |
//
//  A write item or a busy tick skips the scan and goes from idle straight to
//  the decide step. A tick visits k = 1..NUM_WINDOWS windows with the
//  single window-check unit (one window per cycle).
//  s_axis_tready is high only while the sequencer is idle; the result is held
//  in an output register, and a stalled output delays the decide step.
//  Synchronous active-low reset clears the table, valve mode and hold count.
//
module scheduled_thermostat_valve_control (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // entry_index, entry_start_minute, entry_stop_minute, entry_start_temp,
    // entry_stop_temp, entry_enabled, now_hour, now_minute, display_temp,
    // motor_busy, zero fill
    input  logic [stvc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // valve_state, drive_open, drive_close, active_entry, hold_minutes
    output logic [stvc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // skipped
    output logic                           m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import stvc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    t_state                    r_state, n_state;
    t_entry                    r_tbl [NUM_ENTRIES];
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [MIN_W-1:0]          r_now, n_now;
    logic signed [TEMP_W-1:0]  r_disp, n_disp;
    logic                      r_skip, n_skip;
    t_mode                     r_mode, n_mode;
    logic [HOLD_W-1:0]         r_hold, n_hold;
    logic                      r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data, n_out_data;
    logic                      r_out_user, n_out_user;

    // Input field views
    logic [ENTRY_IDX_W-1:0]    in_index;
    logic [HOUR_W-1:0]         in_hour;
    logic [MINUTE_W-1:0]       in_minute;
    logic [MIN_W-1:0]          in_now_raw;
    logic                      in_take;
    logic                      wr_en;
    t_entry                    wr_entry;

    // Window check unit
    t_entry                    cur;
    logic [MIN_W:0]            span;
    logic [MIN_W:0]            elapsed;
    logic                      hit;

    // Decision
    logic                      dec_open;
    logic                      dec_close;
    logic                      out_free;
    logic                      d_open, d_close;

    assign in_index  = s_axis_tdata[IN_IDX_LO +: ENTRY_IDX_W];
    assign in_hour   = s_axis_tdata[IN_HOUR_LO +: HOUR_W];
    assign in_minute = s_axis_tdata[IN_MINUTE_LO +: MINUTE_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_take   = s_axis_tvalid && s_axis_tready;

    // Minute of day: hour*60 as (hour*64 - hour*4), plus minute
    assign in_now_raw = ({in_hour, 6'b0} - MIN_W'({in_hour, 2'b0}))
                        + MIN_W'(in_minute);

    // Table write request, range checked
    assign wr_en = in_take && (s_axis_tuser == OP_WRITE)
                   && (int'(in_index) <= NUM_WINDOWS);
    always_comb begin
        wr_entry.start_min = day_wrap(s_axis_tdata[IN_START_LO +: MIN_W]);
        wr_entry.stop_min  = day_wrap(s_axis_tdata[IN_STOP_LO +: MIN_W]);
        wr_entry.start_t   = s_axis_tdata[IN_TON_LO +: TEMP_W];
        wr_entry.stop_t    = s_axis_tdata[IN_TOFF_LO +: TEMP_W];
        wr_entry.enabled   = s_axis_tdata[IN_EN_BIT];
    end

    // Check the window at the scan index: span and time since start, mod day
    assign cur = r_tbl[r_idx];
    always_comb begin
        if (cur.stop_min >= cur.start_min) begin
            span = {1'b0, cur.stop_min} - {1'b0, cur.start_min};
        end else begin
            span = {1'b0, cur.stop_min} + {1'b0, DAY_MINUTES} - {1'b0, cur.start_min};
        end
        if (r_now >= cur.start_min) begin
            elapsed = {1'b0, r_now} - {1'b0, cur.start_min};
        end else begin
            elapsed = {1'b0, r_now} + {1'b0, DAY_MINUTES} - {1'b0, cur.start_min};
        end
        hit = cur.enabled && (elapsed < span);
    end

    // Temperature decision on the chosen entry
    assign dec_open  = (cur.start_t > r_disp) && (cur.stop_t > r_disp);
    assign dec_close = (r_disp > cur.stop_t);
    assign out_free  = !r_out_valid || m_axis_tready;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_now       = r_now;
        n_disp      = r_disp;
        n_skip      = r_skip;
        n_mode      = r_mode;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        d_open      = 1'b0;
        d_close     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // Capture the item; start the scan at the first window unless it is skipped
                if (in_take) begin
                    n_now  = day_wrap(in_now_raw);
                    n_disp = s_axis_tdata[IN_DISP_LO +: TEMP_W];
                    n_idx  = IDX_W'(1);
                    n_skip = (s_axis_tuser == OP_WRITE) || s_axis_tdata[IN_BUSY_BIT];
                    n_state = n_skip ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Stop on the first hit, fall back to the base entry at the end
                if (hit) begin
                    n_state = ST_DECIDE;
                end else if (int'(r_idx) == NUM_WINDOWS) begin
                    n_idx   = '0;
                    n_state = ST_DECIDE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DECIDE: begin
                // Update valve state (unless skipped) and load the result once the output is free
                if (out_free) begin
                    if (!r_skip) begin
                        if (dec_open) begin
                            if (r_mode != MODE_OPEN) begin
                                n_mode = MODE_OPEN;
                                d_open = 1'b1;
                                n_hold = '0;
                            end else if (r_hold != HOLD_MAX) begin
                                n_hold = r_hold + HOLD_W'(1);
                            end
                        end else if (dec_close) begin
                            if (r_mode != MODE_CLOSED) begin
                                n_mode  = MODE_CLOSED;
                                d_close = 1'b1;
                                n_hold  = '0;
                            end
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_user  = r_skip;
                    n_out_data  = {n_hold,
                                   r_skip ? ENTRY_IDX_W'(0) : ENTRY_IDX_W'(r_idx),
                                   d_close, d_open, n_mode};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_UNKNOWN;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
            r_skip      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
            r_skip      <= n_skip;
            r_idx       <= n_idx;
        end
        r_now      <= n_now;
        r_disp     <= n_disp;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // Schedule table: cleared by reset, one entry written per in-range write item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_tbl[i] <= '0;
            end
        end else if (wr_en) begin
            r_tbl[IDX_W'(in_index)] <= wr_entry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
